// File: rtl/first_fit_segment_allocator_macros.svh
// Assertion macros for the segment allocator
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH
// assert that a condition implies a consequence on the same edge
`define FFSA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
// assert that a condition implies a consequence on the next edge
`define FFSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`endif

// File: rtl/ffsa_pkg.sv
// Package: types, constants and codes of the segment allocator
`timescale 1ns / 1ps
package ffsa_pkg;
  localparam int MAX_SEGMENTS_DEF = 16;
  localparam int ADDR_WIDTH_DEF = 16;
  localparam int DATA_W = 16;
  localparam int OWNER_W = 8;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE = 2'd1;
  localparam logic [1:0] CMD_COMPACT = 2'd2;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_COMPACT = 3'd1;
  localparam logic [2:0] ST_NOSPACE = 3'd2;
  localparam logic [2:0] ST_NOOWNER = 3'd3;
  localparam logic [2:0] ST_FULL = 3'd4;

  typedef struct packed {
    logic [DATA_W-1:0] len;
    logic [OWNER_W-1:0] owner;
    logic used;
    logic vld;
  } seg_t;

  // per-cycle row operation
  typedef enum logic [2:0] {
    OP_HOLD = 3'd0,
    OP_LEFT = 3'd1,
    OP_RIGHT = 3'd2
  } op_t;

  typedef struct packed {
    op_t op;
    logic upd;
    seg_t wr;
  } cell_ctl_t;
endpackage

// File: rtl/ffsa_cell.sv
// One table cell: holds a segment, shifts left/right or rewrites itself
`timescale 1ns / 1ps
module ffsa_cell
  import ffsa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  op_t       op,
  input  logic      upd,
  input  seg_t      wr,
  input  seg_t      from_left,
  input  seg_t      from_right,
  output seg_t      q
);
  seg_t seg_r, seg_nxt;

  always_comb begin
    seg_nxt = seg_r;
    if (upd) begin
      seg_nxt = wr;
    end else begin
      case (op)
        OP_LEFT:  seg_nxt = from_right;
        OP_RIGHT: seg_nxt = from_left;
        default:  seg_nxt = seg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r.vld <= 1'b0;
    end else begin
      seg_r <= seg_nxt;
    end
  end

  assign q = seg_r;
endmodule

// File: rtl/first_fit_segment_allocator.sv
// Top level: segment allocator built on a shifting row of table cells
// Channel | Direction | Ports
// in      | input     | in_valid, in_ready, in_command, in_owner_id, in_request_size
// out     | output    | out_valid, out_ready, out_status, out_start_address, out_free_total
// cfg     | input     | cfg_valid, cfg_ready, cfg_memory_size
// A command runs S_SCAN, S_DEC and S_SUM from accept to the next accept, with one
// S_EDIT step added for a split and three for a free; a compact runs S_PACK for S_DEC.
// A scan turns the row of cells once in address order; compact then packs the
// owned cells in a second pass over the row. Reset empties the table.
// A waiting result stalls a command only in its final S_SUM state.
`timescale 1ns / 1ps
module first_fit_segment_allocator
  import ffsa_pkg::*;
#(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_command,
  input  logic [OWNER_W-1:0]    in_owner_id,
  input  logic [DATA_W-1:0]     in_request_size,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            out_status,
  output logic [DATA_W-1:0]     out_start_address,
  output logic [DATA_W-1:0]     out_free_total,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [DATA_W-1:0]     cfg_memory_size
);
`include "first_fit_segment_allocator_macros.svh"
  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);

  // The row rotates: cell 0 is the head. A full turn visits every entry in
  // address order while tracking the running address and free sum.
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_DEC   = 6'b000100,
    S_EDIT  = 6'b001000,
    S_PACK  = 6'b010000,
    S_SUM   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  seg_t   cell_q [MAX_SEGMENTS];
  cell_ctl_t ctl [MAX_SEGMENTS];

  logic [DATA_W-1:0]  msize_r;
  logic [1:0]         cmd_r;
  logic [OWNER_W-1:0] own_r;
  logic [DATA_W-1:0]  req_r;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [IW-1:0]      step_r, step_nxt;
  logic [ADDR_WIDTH-1:0] addr_r, addr_nxt;
  logic [DATA_W-1:0]  fsum_r, fsum_nxt;
  logic               hit_r, hit_nxt;
  logic [IW-1:0]      hidx_r, hidx_nxt;
  logic [ADDR_WIDTH-1:0] haddr_r, haddr_nxt;
  logic [1:0]         sub_r, sub_nxt;
  logic [IW-1:0]      wcnt_r, wcnt_nxt;
  logic               wfull_r, wfull_nxt;
  logic [2:0]         st_r, st_nxt;
  logic [DATA_W-1:0]  sa_r, sa_nxt;
  logic               ovld_r;
  logic [2:0]         ost_r;
  logic [DATA_W-1:0]  osa_r, oft_r;
  logic               last_step;

  // rotation of the head cell to the tail
  logic rot;

  genvar g;
  generate
    for (g = 0; g < MAX_SEGMENTS; g++) begin : g_row
      seg_t fl, fr;
      assign fl = cell_q[(g + MAX_SEGMENTS - 1) % MAX_SEGMENTS];
      assign fr = cell_q[(g + 1) % MAX_SEGMENTS];
      ffsa_cell u_cell (
        .clk(clk), .rst_n(rst_n), .op(ctl[g].op), .upd(ctl[g].upd),
        .wr(ctl[g].wr), .from_left(fl), .from_right(fr), .q(cell_q[g])
      );
    end
  endgenerate

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign last_step = (step_r == IW'(MAX_SEGMENTS - 1));

  // Working scheme: entries 0..cnt-1 live in cells 0..cnt-1 when idle.
  // Scan: rotate a full turn (MAX_SEGMENTS steps), inspecting cell 0.
  // Edit: act on the hit index, shifting the cells above it (a free may shift twice to merge).
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    step_nxt  = step_r;
    addr_nxt  = addr_r;
    fsum_nxt  = fsum_r;
    hit_nxt   = hit_r;
    hidx_nxt  = hidx_r;
    haddr_nxt = haddr_r;
    sub_nxt   = sub_r;
    wcnt_nxt  = wcnt_r;
    wfull_nxt = wfull_r;
    st_nxt    = st_r;
    sa_nxt    = sa_r;
    rot       = 1'b0;
    for (int k = 0; k < MAX_SEGMENTS; k++) begin
      ctl[k].op  = OP_HOLD;
      ctl[k].upd = 1'b0;
      ctl[k].wr  = cell_q[k];
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          step_nxt = '0;
          addr_nxt = '0;
          fsum_nxt = '0;
          hit_nxt  = 1'b0;
          hidx_nxt = '0;
          haddr_nxt = '0;
          sub_nxt  = '0;
          st_nxt   = ST_OK;
          sa_nxt   = '0;
          wcnt_nxt = '0;
          wfull_nxt = 1'b0;
          if (in_command == CMD_ALLOC && cnt_r == '0) begin
            ctl[0].upd = 1'b1;
            ctl[0].wr  = '{len: msize_r, owner: '0, used: 1'b0, vld: 1'b1};
            cnt_nxt = CW'(1);
          end
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        rot = 1'b1;
        if (cell_q[0].vld && !hit_r) begin
          if (cmd_r == CMD_ALLOC && !cell_q[0].used && cell_q[0].len >= req_r
              && req_r != '0) begin
            hit_nxt = 1'b1; hidx_nxt = step_r; haddr_nxt = addr_r;
          end
          if (cmd_r == CMD_FREE && cell_q[0].used && cell_q[0].owner == own_r) begin
            hit_nxt = 1'b1; hidx_nxt = step_r;
          end
        end
        if (cell_q[0].vld) begin
          addr_nxt = addr_r + ADDR_WIDTH'(cell_q[0].len);
          if (!cell_q[0].used) fsum_nxt = fsum_r + cell_q[0].len;
        end
        step_nxt = step_r + 1'b1;
        if (last_step) begin
          step_nxt  = '0;
          state_nxt = (cmd_r == CMD_COMPACT) ? S_PACK : S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = S_SUM;
        if (cmd_r == CMD_ALLOC) begin
          if (req_r == '0) begin
            st_nxt = ST_NOSPACE;
          end else if (!hit_r) begin
            st_nxt = (fsum_r >= req_r) ? ST_COMPACT : ST_NOSPACE;
          end else if (cell_q[hidx_r].len > req_r) begin
            if (cnt_r >= CW'(MAX_SEGMENTS)) begin
              st_nxt = ST_FULL;
            end else begin
              sa_nxt = DATA_W'(haddr_r);
              state_nxt = S_EDIT;
            end
          end else begin
            ctl[hidx_r].upd = 1'b1;
            ctl[hidx_r].wr  = '{len: cell_q[hidx_r].len, owner: own_r,
                               used: 1'b1, vld: 1'b1};
            sa_nxt = DATA_W'(haddr_r);
          end
        end else if (cmd_r == CMD_FREE) begin
          if (!hit_r) begin
            st_nxt = ST_NOOWNER;
          end else begin
            fsum_nxt = fsum_r + cell_q[hidx_r].len;
            sub_nxt = '0;
            state_nxt = S_EDIT;
          end
        end
      end
      S_EDIT: begin
        if (cmd_r == CMD_ALLOC) begin
          // open slot at hidx+1: shift cells above hidx right
          for (int k = 0; k < MAX_SEGMENTS; k++) begin
            if (IW'(k) > hidx_r) ctl[k].op = OP_RIGHT;
          end
          ctl[hidx_r].upd = 1'b1;
          ctl[hidx_r].wr  = '{len: req_r, owner: own_r, used: 1'b1, vld: 1'b1};
          if (32'(hidx_r) + 1 < MAX_SEGMENTS) begin
            ctl[IW'(32'(hidx_r) + 1)].upd = 1'b1;
            ctl[IW'(32'(hidx_r) + 1)].wr  = '{len: cell_q[hidx_r].len - req_r,
                                             owner: '0, used: 1'b0, vld: 1'b1};
          end
          cnt_nxt = cnt_r + 1'b1;
          state_nxt = S_SUM;
        end else begin
          unique case (sub_r)
            2'd0: begin
              ctl[hidx_r].upd = 1'b1;
              ctl[hidx_r].wr  = '{len: cell_q[hidx_r].len, owner: '0,
                                 used: 1'b0, vld: 1'b1};
              sub_nxt = 2'd1;
            end
            2'd1: begin
              sub_nxt = 2'd2;
              if (32'(hidx_r) + 1 < MAX_SEGMENTS) begin
                if (cell_q[IW'(32'(hidx_r) + 1)].vld &&
                    !cell_q[IW'(32'(hidx_r) + 1)].used) begin
                  for (int k = 0; k < MAX_SEGMENTS; k++) begin
                    if (IW'(k) > hidx_r) ctl[k].op = OP_LEFT;
                  end
                  ctl[MAX_SEGMENTS-1].op  = OP_HOLD;
                  ctl[MAX_SEGMENTS-1].upd = 1'b1;
                  ctl[MAX_SEGMENTS-1].wr  = '0;
                  ctl[hidx_r].upd = 1'b1;
                  ctl[hidx_r].wr  = '{len: cell_q[hidx_r].len +
                                     cell_q[IW'(32'(hidx_r) + 1)].len,
                                     owner: '0, used: 1'b0, vld: 1'b1};
                  cnt_nxt = cnt_r - 1'b1;
                end
              end
            end
            default: begin
              state_nxt = S_SUM;
              if (hidx_r != '0 && !cell_q[hidx_r - 1'b1].used) begin
                for (int k = 0; k < MAX_SEGMENTS; k++) begin
                  if (IW'(k) >= hidx_r) ctl[k].op = OP_LEFT;
                end
                ctl[MAX_SEGMENTS-1].op  = OP_HOLD;
                ctl[MAX_SEGMENTS-1].upd = 1'b1;
                ctl[MAX_SEGMENTS-1].wr  = '0;
                ctl[hidx_r - 1'b1].upd = 1'b1;
                ctl[hidx_r - 1'b1].wr  = '{len: cell_q[hidx_r - 1'b1].len +
                                          cell_q[hidx_r].len,
                                          owner: '0, used: 1'b0, vld: 1'b1};
                cnt_nxt = cnt_r - 1'b1;
              end
            end
          endcase
        end
      end
      S_PACK: begin
        // walk the row; move each owned cell down to slot wcnt, clear the rest
        ctl[step_r].upd = 1'b1;
        ctl[step_r].wr  = '0;
        if (cell_q[step_r].vld && cell_q[step_r].used) begin
          ctl[wcnt_r].upd = 1'b1;
          ctl[wcnt_r].wr  = cell_q[step_r];
          wcnt_nxt = wcnt_r + 1'b1;
          if (wcnt_r == IW'(MAX_SEGMENTS - 1)) wfull_nxt = 1'b1;
        end
        step_nxt = step_r + 1'b1;
        if (last_step) begin
          step_nxt = '0;
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        // hold while the previous result still waits
        if (!ovld_r) begin
          state_nxt = S_IDLE;
          if (cmd_r == CMD_COMPACT && cnt_r != '0) begin
            cnt_nxt = wfull_r ? CW'(MAX_SEGMENTS) : CW'(wcnt_r);
            if (fsum_r != '0 && !wfull_r) begin
              ctl[wcnt_r].upd = 1'b1;
              ctl[wcnt_r].wr  = '{len: fsum_r, owner: '0, used: 1'b0, vld: 1'b1};
              cnt_nxt = CW'(wcnt_r) + 1'b1;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (rot) begin
      for (int k = 0; k < MAX_SEGMENTS; k++) begin
        ctl[k].op = OP_LEFT;
      end
    end
  end

  // free sum after the command, derived from the free sum gathered in the scan
  logic [DATA_W-1:0] ftot;
  always_comb begin
    ftot = '0;
    if (cmd_r == CMD_COMPACT) ftot = fsum_r;
    else if (cmd_r == CMD_ALLOC && st_r == ST_OK && hit_r && req_r != '0)
      ftot = fsum_r - req_r;
    else ftot = fsum_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      msize_r <= '1;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_valid && cfg_ready) msize_r <= cfg_memory_size;
      if (ovld_r && out_ready) ovld_r <= 1'b0;
      if (state_r == S_SUM && !ovld_r) begin
        ovld_r <= 1'b1;
        ost_r  <= st_r;
        osa_r  <= (st_r == ST_OK && cmd_r == CMD_ALLOC) ? sa_r : '0;
        oft_r  <= ftot;
      end
    end
  end

  always_ff @(posedge clk) begin
    step_r  <= step_nxt;
    addr_r  <= addr_nxt;
    fsum_r  <= fsum_nxt;
    hit_r   <= hit_nxt;
    hidx_r  <= hidx_nxt;
    haddr_r <= haddr_nxt;
    sub_r   <= sub_nxt;
    wcnt_r  <= wcnt_nxt;
    wfull_r <= wfull_nxt;
    st_r    <= st_nxt;
    sa_r    <= sa_nxt;
    if (state_r == S_IDLE && in_valid) begin
      cmd_r <= in_command;
      own_r <= in_owner_id;
      req_r <= in_request_size;
    end
  end

  assign out_valid         = ovld_r;
  assign out_status        = ost_r;
  assign out_start_address = osa_r;
  assign out_free_total    = oft_r;

  `FFSA_ASSERT_IMP(a_cnt_max, 1'b1, cnt_r <= CW'(MAX_SEGMENTS))
  `FFSA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `FFSA_ASSERT_IMP(a_no_accept_busy, state_r != S_IDLE, !in_ready)
endmodule

// File: sim/first_fit_segment_allocator_tb.sv
// Testbench for the first-fit segment allocator: random and directed commands
// checked against a behavioral table model
`timescale 1ns / 1ps
module first_fit_segment_allocator_tb;
  import ffsa_pkg::*;

  localparam int SEG_SLOTS = 16;
  localparam int STALL_LIMIT = 5000;
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  owner;
    logic [15:0] size;
  } alloc_cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] addr;
    logic [15:0] free_total;
  } alloc_rsp_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_command;
  logic [7:0]  in_owner_id;
  logic [15:0] in_request_size;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_status;
  logic [15:0] out_start_address;
  logic [15:0] out_free_total;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_memory_size;

  alloc_cmd_t  pending_cmds[$];
  alloc_rsp_t  expected_rsps[$];
  int          send_idle_pct;
  int          recv_idle_pct;
  int          error_count;
  int          quiet_cycles;

  int unsigned seg_base[SEG_SLOTS];
  int unsigned seg_len[SEG_SLOTS];
  logic [7:0]  seg_own[SEG_SLOTS];
  logic        seg_busy[SEG_SLOTS];
  int          seg_n;
  int unsigned mem_size;

  first_fit_segment_allocator uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_command(in_command),
    .in_owner_id(in_owner_id),
    .in_request_size(in_request_size),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_start_address(out_start_address),
    .out_free_total(out_free_total),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_memory_size(cfg_memory_size)
  );

  function automatic int unsigned free_space();
    int unsigned total;
    total = 0;
    for (int k = 0; k < seg_n; k++) begin
      if (!seg_busy[k]) total += seg_len[k];
    end
    return total;
  endfunction

  function automatic void remove_seg(int idx);
    for (int k = idx; k + 1 < seg_n; k++) begin
      seg_base[k] = seg_base[k+1];
      seg_len[k] = seg_len[k+1];
      seg_own[k] = seg_own[k+1];
      seg_busy[k] = seg_busy[k+1];
    end
    if (seg_n > 0) seg_n--;
  endfunction

  function automatic alloc_rsp_t apply_command(alloc_cmd_t c);
    alloc_rsp_t r;
    int idx;
    int w;
    int unsigned total;
    int unsigned addr;
    r = '0;
    if (c.cmd == CMD_ALLOC) begin
      if (seg_n == 0) begin
        seg_base[0] = 0;
        seg_len[0] = mem_size;
        seg_own[0] = '0;
        seg_busy[0] = 1'b0;
        seg_n = 1;
      end
      if (c.size == 0) begin
        r.status = ST_NOSPACE;
      end else begin
        idx = seg_n;
        for (int k = seg_n - 1; k >= 0; k--) begin
          if (!seg_busy[k] && seg_len[k] >= c.size) idx = k;
        end
        if (idx == seg_n) begin
          r.status = (free_space() >= c.size) ? ST_COMPACT : ST_NOSPACE;
        end else if (seg_len[idx] > c.size && seg_n >= SEG_SLOTS) begin
          r.status = ST_FULL;
        end else begin
          if (seg_len[idx] > c.size) begin
            for (int k = seg_n; k > idx + 1; k--) begin
              seg_base[k] = seg_base[k-1];
              seg_len[k] = seg_len[k-1];
              seg_own[k] = seg_own[k-1];
              seg_busy[k] = seg_busy[k-1];
            end
            seg_n++;
            seg_base[idx+1] = seg_base[idx] + c.size;
            seg_len[idx+1] = seg_len[idx] - c.size;
            seg_own[idx+1] = '0;
            seg_busy[idx+1] = 1'b0;
            seg_len[idx] = c.size;
          end
          seg_busy[idx] = 1'b1;
          seg_own[idx] = c.owner;
          r.status = ST_OK;
          r.addr = seg_base[idx][15:0];
        end
      end
    end else if (c.cmd == CMD_FREE) begin
      idx = seg_n;
      for (int k = seg_n - 1; k >= 0; k--) begin
        if (seg_busy[k] && seg_own[k] == c.owner) idx = k;
      end
      if (idx == seg_n) begin
        r.status = ST_NOOWNER;
      end else begin
        seg_busy[idx] = 1'b0;
        seg_own[idx] = '0;
        if (idx + 1 < seg_n && !seg_busy[idx+1]) begin
          seg_len[idx] += seg_len[idx+1];
          remove_seg(idx + 1);
        end
        if (idx > 0 && !seg_busy[idx-1]) begin
          seg_len[idx-1] += seg_len[idx];
          remove_seg(idx);
        end
        r.status = ST_OK;
      end
    end else if (c.cmd == CMD_COMPACT && seg_n > 0) begin
      total = free_space();
      addr = 0;
      w = 0;
      for (int k = 0; k < seg_n; k++) begin
        if (seg_busy[k]) begin
          seg_base[w] = addr;
          seg_len[w] = seg_len[k];
          seg_own[w] = seg_own[k];
          seg_busy[w] = 1'b1;
          addr += seg_len[k];
          w++;
        end
      end
      if (total > 0 && w < SEG_SLOTS) begin
        seg_base[w] = addr;
        seg_len[w] = total;
        seg_own[w] = '0;
        seg_busy[w] = 1'b0;
        w++;
      end
      seg_n = w;
    end
    r.free_total = 16'(free_space());
    return r;
  endfunction

  function automatic alloc_cmd_t make_cmd(logic [1:0] c, logic [7:0] o, logic [15:0] s);
    alloc_cmd_t x;
    x.cmd = c;
    x.owner = o;
    x.size = s;
    return x;
  endfunction

  function automatic alloc_cmd_t random_cmd();
    alloc_cmd_t x;
    int pick;
    x.owner = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(15));
    pick = $urandom_range(99);
    if (pick < 5) x.size = '0;
    else if (pick < 65) x.size = 16'($urandom_range(3000, 1));
    else if (pick < 90) x.size = 16'($urandom_range(20000, 1));
    else x.size = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 50) x.cmd = CMD_ALLOC;
    else if (pick < 85) x.cmd = CMD_FREE;
    else if (pick < 93) x.cmd = CMD_COMPACT;
    else x.cmd = CMD_UNKNOWN;
    return x;
  endfunction

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_cmds.size() != 0 || in_valid || expected_rsps.size() != 0);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_mem_size(logic [15:0] value);
    cfg_memory_size <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    mem_size = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(int count, int s_idle, int r_idle);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int n = 0; n < count; n++) pending_cmds.push_back(random_cmd());
    wait_drained();
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = '0;
    in_owner_id = '0;
    in_request_size = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_memory_size = '0;
    forever #5 clk = ~clk;
  end

  initial begin
    error_count = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    seg_n = 0;
    mem_size = 65535;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_mem_size(16'd0);
    pending_cmds.push_back(make_cmd(CMD_ALLOC, 8'd1, 16'd5));
    pending_cmds.push_back(make_cmd(CMD_ALLOC, 8'd1, 16'd0));
    pending_cmds.push_back(make_cmd(CMD_COMPACT, 8'd0, 16'd0));
    pending_cmds.push_back(make_cmd(CMD_FREE, 8'd1, 16'd0));
    pending_cmds.push_back(make_cmd(CMD_COMPACT, 8'd0, 16'd0));
    pending_cmds.push_back(make_cmd(CMD_UNKNOWN, 8'hFF, 16'hFFFF));
    wait_drained();

    write_mem_size(16'd65535);
    pending_cmds.push_back(make_cmd(CMD_ALLOC, 8'd0, 16'd0));
    pending_cmds.push_back(make_cmd(CMD_ALLOC, 8'd255, 16'd65535));
    pending_cmds.push_back(make_cmd(CMD_ALLOC, 8'd2, 16'd1));
    pending_cmds.push_back(make_cmd(CMD_FREE, 8'd255, 16'd0));
    pending_cmds.push_back(make_cmd(CMD_FREE, 8'd255, 16'd0));
    for (int k = 1; k <= 15; k++) begin
      pending_cmds.push_back(make_cmd(CMD_ALLOC, 8'(k), 16'd4000));
    end
    pending_cmds.push_back(make_cmd(CMD_FREE, 8'd3, 16'd0));
    pending_cmds.push_back(make_cmd(CMD_ALLOC, 8'hAA, 16'd6000));
    pending_cmds.push_back(make_cmd(CMD_COMPACT, 8'd0, 16'd0));
    wait_drained();

    run_random(390, 0, 0);
    write_mem_size(16'd1);
    run_random(390, 61, 0);
    write_mem_size(16'd32768);
    run_random(390, 0, 61);
    write_mem_size(16'd65535);
    run_random(390, 36, 36);

    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_rsps.push_back(apply_command(make_cmd(in_command, in_owner_id,
                                                       in_request_size)));
      end
      if (!in_valid || in_ready) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          alloc_cmd_t nxt;
          nxt = pending_cmds.pop_front();
          in_valid <= 1'b1;
          in_command <= nxt.cmd;
          in_owner_id <= nxt.owner;
          in_request_size <= nxt.size;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_rsps.size() == 0) begin
          $error("unexpected transaction: status %0d", out_status);
          error_count++;
        end else begin
          alloc_rsp_t exp_rsp;
          exp_rsp = expected_rsps.pop_front();
          if (out_status !== exp_rsp.status) begin
            $error("status: expected %0d actual %0d", exp_rsp.status, out_status);
            error_count++;
          end
          if (out_start_address !== exp_rsp.addr) begin
            $error("start_address: expected %0d actual %0d", exp_rsp.addr,
                   out_start_address);
            error_count++;
          end
          if (out_free_total !== exp_rsp.free_total) begin
            $error("free_total: expected %0d actual %0d", exp_rsp.free_total,
                   out_free_total);
            error_count++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)
                 || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
